/* design/stok_pkg.sv */
// stok_pkg: token kinds, result record and byte classification helpers
// for the source tokenizer. No dependencies.
`default_nettype none

package stok_pkg;

  // Token kinds, in output code order.
  typedef enum logic [5:0] {
    K_IDENT, K_FOR, K_IF, K_ELSE, K_WHILE, K_RETURN, K_ELSEIF,
    K_INT, K_FLOAT,
    K_LPAREN, K_RPAREN, K_ADD_ASGN, K_ADD, K_SUB_ASGN, K_SUB,
    K_MUL_ASGN, K_MUL, K_DIV_ASGN, K_DIV, K_COLON, K_EQ, K_ASGN,
    K_NE, K_NOT, K_LAND, K_BAND, K_LOR, K_BOR, K_LE, K_LT, K_GE, K_GT,
    K_EMUL, K_EDIV, K_EPOW, K_EMOD, K_DOT, K_POW, K_COMMA,
    K_MOD_ASGN, K_MOD,
    K_END, K_BAD_CHAR, K_BAD_NUM
  } kind_e;

  localparam int unsigned FIELD_MAX   = 65535;
  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned QDEPTH      = 4;

  // Keyword text, packed with the first byte highest.
  localparam logic [47:0] KW_FOR    = 48'h0000_0066_6F72;
  localparam logic [47:0] KW_IF     = 48'h0000_0000_6966;
  localparam logic [47:0] KW_ELSE   = 48'h0000_656C_7365;
  localparam logic [47:0] KW_WHILE  = 48'h0077_6869_6C65;
  localparam logic [47:0] KW_RETURN = 48'h7265_7475_726E;
  localparam logic [47:0] KW_ELSEIF = 48'h656C_7365_6966;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic        run_end;
  } res_t;

  // Results of one step, packed at the low slots.
  typedef struct packed {
    logic [1:0]       cnt;
    res_t [2:0]       item;
  } step_res_t;

  function automatic logic is_letter(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic logic is_numeral(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_blank(logic [7:0] b);
    return b == " " || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic lone_hit(logic [7:0] b);
    return b == "(" || b == ")" || b == ":" || b == "^" || b == ",";
  endfunction

  function automatic kind_e lone_kind(logic [7:0] b);
    kind_e k;
    unique case (b)
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      ":":     k = K_COLON;
      "^":     k = K_POW;
      ",":     k = K_COMMA;
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

  function automatic logic held_hit(logic [7:0] b);
    return b == "+" || b == "-" || b == "*" || b == "/" || b == "=" ||
           b == "!" || b == "&" || b == "|" || b == "<" || b == ">" ||
           b == "." || b == "%";
  endfunction

  function automatic kind_e held_kind(logic [7:0] b);
    kind_e k;
    unique case (b)
      "+":     k = K_ADD;
      "-":     k = K_SUB;
      "*":     k = K_MUL;
      "/":     k = K_DIV;
      "=":     k = K_ASGN;
      "!":     k = K_NOT;
      "&":     k = K_BAND;
      "|":     k = K_BOR;
      "<":     k = K_LT;
      ">":     k = K_GT;
      ".":     k = K_DOT;
      "%":     k = K_MOD;
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

  function automatic logic pair_hit(logic [7:0] h, logic [7:0] b);
    logic hit;
    priority if (h == ".") hit = (b == "*" || b == "/" || b == "^" || b == "%");
    else if (h == "&")     hit = (b == "&");
    else if (h == "|")     hit = (b == "|");
    else                   hit = (b == "=") &&
                                 (h == "+" || h == "-" || h == "*" || h == "/" ||
                                  h == "=" || h == "!" || h == "<" || h == ">" ||
                                  h == "%");
    return hit;
  endfunction

  function automatic kind_e pair_kind(logic [7:0] h, logic [7:0] b);
    kind_e k;
    k = K_IDENT;
    if (h == ".") begin
      unique case (b)
        "*":     k = K_EMUL;
        "/":     k = K_EDIV;
        "^":     k = K_EPOW;
        "%":     k = K_EMOD;
        default: k = K_IDENT;
      endcase
    end else begin
      unique case (h)
        "&":     k = K_LAND;
        "|":     k = K_LOR;
        "+":     k = K_ADD_ASGN;
        "-":     k = K_SUB_ASGN;
        "*":     k = K_MUL_ASGN;
        "/":     k = K_DIV_ASGN;
        "=":     k = K_EQ;
        "!":     k = K_NE;
        "<":     k = K_LE;
        ">":     k = K_GE;
        "%":     k = K_MOD_ASGN;
        default: k = K_IDENT;
      endcase
    end
    return k;
  endfunction

  function automatic kind_e word_kind(logic [47:0] w, logic too_long);
    kind_e k;
    priority if (too_long) k = K_IDENT;
    else if (w == KW_FOR)    k = K_FOR;
    else if (w == KW_IF)     k = K_IF;
    else if (w == KW_ELSE)   k = K_ELSE;
    else if (w == KW_WHILE)  k = K_WHILE;
    else if (w == KW_RETURN) k = K_RETURN;
    else if (w == KW_ELSEIF) k = K_ELSEIF;
    else                     k = K_IDENT;
    return k;
  endfunction

endpackage

`default_nettype wire

/* design/stok_if.sv */
// stok_in_if / stok_out_if: valid-ready channels for source bytes and tokens.
// No dependencies.
`default_nettype none

interface stok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       final_byte;
  modport source (output valid, char_code, final_byte, input ready);
  modport sink   (input valid, char_code, final_byte, output ready);
endinterface

interface stok_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  kind;
  logic [15:0] start_offset;
  logic [15:0] token_length;
  logic        run_end;
  modport source (output valid, kind, start_offset, token_length, run_end,
                  input ready);
  modport sink   (input valid, kind, start_offset, token_length, run_end,
                  output ready);
endinterface

`default_nettype wire

/* design/stok_core.sv */
// stok_core: scanner state and the per-byte step, up to three results a byte.
// Depends on stok_pkg.
`default_nettype none

module stok_core #(
  parameter int unsigned OffsetBits = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [7:0]        char_code_i,
  input  wire logic              final_byte_i,
  output stok_pkg::step_res_t    res_o
);
  import stok_pkg::*;

  localparam int unsigned WideBits = (OffsetBits > 16) ? OffsetBits : 16;
  localparam logic [OffsetBits-1:0] OffMax = '1;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_WORD, MODE_NUMBER, MODE_HELD, MODE_DROP
  } mode_e;

  mode_e                 mode_q, mode_d;
  logic [7:0]            hop_q, hop_d;
  logic [47:0]           pref_q, pref_d;
  logic                  tl_q, tl_d;
  logic                  dot_q, dot_d;
  logic [OffsetBits-1:0] pos_q, pos_d;
  logic [OffsetBits-1:0] tb_q, tb_d;

  logic [OffsetBits-1:0] nxt;
  logic                  used;
  res_t                  e [4];
  logic [3:0]            ev;
  res_t [2:0]            slot;
  logic [1:0]            n;

  function automatic logic [15:0] clip_f(logic [OffsetBits-1:0] v);
    logic [WideBits-1:0] x;
    x = WideBits'(v);
    if (x > WideBits'(FIELD_MAX)) return 16'hFFFF;
    return x[15:0];
  endfunction

  function automatic logic [15:0] len_f(logic [OffsetBits-1:0] fin,
                                        logic [OffsetBits-1:0] beg);
    logic [OffsetBits-1:0] d;
    d = (fin >= beg) ? fin - beg : '0;
    return clip_f(d);
  endfunction

  function automatic logic pending_f(mode_e m);
    return m == MODE_WORD || m == MODE_NUMBER || m == MODE_HELD;
  endfunction

  // Token left open in mode m, closed at offset fin.
  function automatic res_t flush_f(mode_e m, logic [47:0] w, logic tl,
                                   logic dot, logic [7:0] h,
                                   logic [OffsetBits-1:0] beg,
                                   logic [OffsetBits-1:0] fin);
    res_t r;
    r.start_offset = clip_f(beg);
    r.token_length = len_f(fin, beg);
    r.run_end      = 1'b0;
    unique case (m)
      MODE_WORD:   r.kind = word_kind(w, tl);
      MODE_NUMBER: r.kind = dot ? K_FLOAT : K_INT;
      MODE_HELD:   r.kind = held_kind(h);
      default:     r.kind = K_IDENT;
    endcase
    return r;
  endfunction

  always_comb begin
    mode_d = mode_q;
    hop_d  = hop_q;
    pref_d = pref_q;
    tl_d   = tl_q;
    dot_d  = dot_q;
    pos_d  = pos_q;
    tb_d   = tb_q;
    nxt    = (pos_q != OffMax) ? pos_q + 1'b1 : pos_q;
    used   = 1'b0;
    ev     = '0;
    for (int i = 0; i < 4; i++) e[i] = '0;

    // Continue the open token, or close it.
    unique case (mode_q)
      MODE_WORD: begin
        if (is_letter(char_code_i) || is_numeral(char_code_i)) begin
          used = 1'b1;
          if (pref_q[47:40] != 8'd0) tl_d = 1'b1;
          else                       pref_d = {pref_q[39:0], char_code_i};
        end else begin
          ev[0]  = 1'b1;
          e[0]   = flush_f(mode_q, pref_q, tl_q, dot_q, hop_q, tb_q, pos_q);
          mode_d = MODE_IDLE;
        end
      end
      MODE_NUMBER: begin
        if (is_numeral(char_code_i)) begin
          used = 1'b1;
        end else if (char_code_i == ".") begin
          used = 1'b1;
          if (dot_q) begin
            ev[0]  = 1'b1;
            e[0]   = '{kind: K_BAD_NUM, start_offset: clip_f(pos_q),
                       token_length: 16'd1, run_end: 1'b1};
            mode_d = MODE_DROP;
          end else begin
            dot_d = 1'b1;
          end
        end else begin
          ev[0]  = 1'b1;
          e[0]   = flush_f(mode_q, pref_q, tl_q, dot_q, hop_q, tb_q, pos_q);
          mode_d = MODE_IDLE;
        end
      end
      MODE_HELD: begin
        ev[0]  = 1'b1;
        mode_d = MODE_IDLE;
        if (pair_hit(hop_q, char_code_i)) begin
          used = 1'b1;
          e[0] = '{kind: pair_kind(hop_q, char_code_i), start_offset: clip_f(tb_q),
                   token_length: len_f(nxt, tb_q), run_end: 1'b0};
        end else begin
          e[0] = flush_f(mode_q, pref_q, tl_q, dot_q, hop_q, tb_q, pos_q);
        end
      end
      MODE_IDLE, MODE_DROP: ;
      default: ;
    endcase

    // Start a new token with this byte.
    if (mode_q != MODE_DROP && !used) begin
      priority if (is_letter(char_code_i)) begin
        mode_d = MODE_WORD;
        tb_d   = pos_q;
        pref_d = {40'd0, char_code_i};
        tl_d   = 1'b0;
      end else if (is_numeral(char_code_i)) begin
        mode_d = MODE_NUMBER;
        tb_d   = pos_q;
        dot_d  = 1'b0;
      end else if (is_blank(char_code_i)) begin
        mode_d = MODE_IDLE;
      end else if (lone_hit(char_code_i)) begin
        ev[1] = 1'b1;
        e[1]  = '{kind: lone_kind(char_code_i), start_offset: clip_f(pos_q),
                  token_length: 16'd1, run_end: 1'b0};
      end else if (held_hit(char_code_i)) begin
        mode_d = MODE_HELD;
        hop_d  = char_code_i;
        tb_d   = pos_q;
      end else begin
        ev[1]  = 1'b1;
        e[1]   = '{kind: K_BAD_CHAR, start_offset: clip_f(pos_q),
                   token_length: 16'd1, run_end: 1'b1};
        mode_d = MODE_DROP;
      end
    end

    // Last byte: close any open token, then the end token; clear all.
    if (mode_q != MODE_DROP && mode_d != MODE_DROP && final_byte_i) begin
      ev[2] = pending_f(mode_d);
      e[2]  = flush_f(mode_d, pref_d, tl_d, dot_d, hop_d, tb_d, nxt);
      ev[3] = 1'b1;
      e[3]  = '{kind: K_END, start_offset: clip_f(nxt),
                token_length: 16'd0, run_end: 1'b1};
    end

    if (final_byte_i) begin
      mode_d = MODE_IDLE;
      hop_d  = '0;
      pref_d = '0;
      tl_d   = 1'b0;
      dot_d  = 1'b0;
      pos_d  = '0;
      tb_d   = '0;
    end else if (mode_q != MODE_DROP) begin
      pos_d = nxt;
    end

    // Pack the results into the low slots in order.
    n    = '0;
    slot = '0;
    for (int i = 0; i < 4; i++) begin
      if (ev[i] && n != 2'd3) begin
        slot[n] = e[i];
        n       = n + 2'd1;
      end
    end
    res_o.cnt  = step_i ? n : 2'd0;
    res_o.item = slot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      hop_q  <= '0;
      pref_q <= '0;
      tl_q   <= 1'b0;
      dot_q  <= 1'b0;
      pos_q  <= '0;
      tb_q   <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      hop_q  <= hop_d;
      pref_q <= pref_d;
      tl_q   <= tl_d;
      dot_q  <= dot_d;
      pos_q  <= pos_d;
      tb_q   <= tb_d;
    end
  end

endmodule

`default_nettype wire

/* design/source_tokenizer.sv */
// source_tokenizer: streaming lexer, one source byte in, tokens out.
// An accepted byte is held in the input register, then scanned into the queue.
// Throughput: one byte per cycle while bytes average at most one token and the
//   sink is ready; a byte yields up to three tokens, drained one per ready cycle
//   from a 4-entry token queue; the scanner waits while it holds more than one token.
// Reset (rst_ni, async, low): queue empty, scanner idle, offset 0.
// Depends on stok_pkg, stok_in_if/stok_out_if and stok_core.
`default_nettype none

module source_tokenizer #(
  parameter int unsigned OffsetBits = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  stok_in_if.sink     item_i,
  stok_out_if.source  token_o
);
  import stok_pkg::*;

  localparam int unsigned PtrBits = $clog2(QDEPTH);
  localparam int unsigned CntBits = $clog2(QDEPTH + 1);

  // Input register: one byte waiting for the scanner.
  logic       in_vld_q;
  logic [7:0] char_q;
  logic       final_q;

  // Token queue.
  res_t               fifo_q [QDEPTH];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] cnt_q;

  logic      room;
  logic      fire;
  logic      pop;
  step_res_t step_res;

  // The scanner steps only when the queue can absorb a full three-token burst.
  assign room = cnt_q <= CntBits'(QDEPTH - MAX_RESULTS);
  assign fire = in_vld_q && room;
  assign pop  = token_o.valid && token_o.ready;

  assign item_i.ready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (item_i.ready) begin
      in_vld_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      char_q  <= item_i.char_code;
      final_q <= item_i.final_byte;
    end
  end

  stok_core #(
    .OffsetBits (OffsetBits)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (fire),
    .char_code_i  (char_q),
    .final_byte_i (final_q),
    .res_o        (step_res)
  );

  // Tokens of one step land in consecutive queue slots.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (i < int'(step_res.cnt)) begin
        fifo_q[wr_ptr_q + PtrBits'(i)] <= step_res.item[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrBits'(step_res.cnt);
      rd_ptr_q <= rd_ptr_q + PtrBits'(pop);
      cnt_q    <= cnt_q + CntBits'(step_res.cnt) - CntBits'(pop);
    end
  end

  assign token_o.valid        = cnt_q != '0;
  assign token_o.kind         = fifo_q[rd_ptr_q].kind;
  assign token_o.start_offset = fifo_q[rd_ptr_q].start_offset;
  assign token_o.token_length = fifo_q[rd_ptr_q].token_length;
  assign token_o.run_end      = fifo_q[rd_ptr_q].run_end;

endmodule

`default_nettype wire

/* test/tb.sv */
// tb: self-checking bench for source_tokenizer. Streams source bytes in and
// checks every token against a lexer model kept inside the bench or typed in.
// Depends on stok_pkg, stok_in_if / stok_out_if and the design sources.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stok_pkg::*;

  localparam int unsigned LIMIT_CYCLES    = 400_000;
  localparam int unsigned RANDOM_BYTES    = 90;
  localparam int unsigned DRAIN_CYCLES    = 20;   // latency plus a full token queue
  localparam int unsigned HOLD_OFF_CYCLES = 120;
  localparam logic [15:0] POS_MAX         = 16'hFFFF;

  // Operator spellings in kind order, K_LPAREN first; keywords in kind order.
  localparam logic [15:0] OP_TEXT [32] = '{
    "(", ")", "+=", "+", "-=", "-", "*=", "*", "/=", "/", ":", "==", "=",
    "!=", "!", "&&", "&", "||", "|", "<=", "<", ">=", ">", ".*", "./",
    ".^", ".%", ".", "^", ",", "%=", "%"
  };
  localparam logic [47:0] KEYWORD_TEXT [6] = '{
    "for", "if", "else", "while", "return", "elseif"
  };
  localparam kind_e KEYWORD_KIND [6] = '{
    K_FOR, K_IF, K_ELSE, K_WHILE, K_RETURN, K_ELSEIF
  };
  localparam logic [7:0] BLANK_CHARS [6] = '{" ", 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_WORD, SCAN_NUMBER, SCAN_HELD, SCAN_DROP
  } scan_e;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_EVERY_THIRD, SINK_MOSTLY} sink_style_e;

  // One byte waiting to go out; typed marks a source whose tokens were
  // entered by hand, so the lexer model only tracks state for it.
  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       typed;
  } src_byte_t;

  typedef struct packed {
    logic [63:0] text;     // bytes right aligned, first byte highest
    logic [3:0]  len;
    logic [1:0]  n_fixed;  // 0: tokens come from the lexer model
    res_t [1:0]  fixed;
  } source_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  stok_in_if  item_if ();
  stok_out_if token_if ();

  source_tokenizer u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .token_o (token_if)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Lexer model: state and token list, advanced once per accepted byte
  // ---------------------------------------------------------------------------
  scan_e       scan_mode = SCAN_IDLE;
  logic [7:0]  held_op   = '0;
  logic [47:0] word_text = '0;  // first six bytes of the current word
  bit          word_long = 1'b0;
  bit          seen_dot  = 1'b0;
  logic [15:0] byte_pos  = '0;
  logic [15:0] tok_begin = '0;

  res_t        step_tokens [$];  // tokens caused by the byte just lexed
  res_t        tokens_due  [$];  // tokens the block still owes, oldest first
  src_byte_t   bytes_out   [$];

  bit          byte_held  = 1'b0;  // sender is offering a byte
  bit          steady     = 1'b0;  // sender sends without gaps
  bit          hold_req   = 1'b0;  // ask the sink for a long hold-off
  int unsigned live_bytes   = 0;   // bytes lexed outside of a dropped tail
  int unsigned sources_sent = 0;
  int unsigned tokens_seen  = 0;
  int unsigned input_stalls = 0;
  int unsigned cycles       = 0;
  int unsigned fails        = 0;

  function automatic bit starts_word(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic bit is_num(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_space(logic [7:0] b);
    return b == " " || (b >= 8'd9 && b <= 8'd13);
  endfunction

  // K_IDENT doubles as "no match" in the three lookups below.
  function automatic kind_e single_kind(logic [7:0] b);
    case (b)
      "(":     return K_LPAREN;
      ")":     return K_RPAREN;
      ":":     return K_COLON;
      "^":     return K_POW;
      ",":     return K_COMMA;
      default: return K_IDENT;
    endcase
  endfunction

  function automatic kind_e alone_kind(logic [7:0] b);
    case (b)
      "+":     return K_ADD;
      "-":     return K_SUB;
      "*":     return K_MUL;
      "/":     return K_DIV;
      "=":     return K_ASGN;
      "!":     return K_NOT;
      "&":     return K_BAND;
      "|":     return K_BOR;
      "<":     return K_LT;
      ">":     return K_GT;
      ".":     return K_DOT;
      "%":     return K_MOD;
      default: return K_IDENT;
    endcase
  endfunction

  function automatic kind_e pair_kind(logic [7:0] h, logic [7:0] b);
    if (h == ".") begin
      case (b)
        "*":     return K_EMUL;
        "/":     return K_EDIV;
        "^":     return K_EPOW;
        "%":     return K_EMOD;
        default: return K_IDENT;
      endcase
    end
    if (h == "&") return (b == "&") ? K_LAND : K_IDENT;
    if (h == "|") return (b == "|") ? K_LOR : K_IDENT;
    if (b != "=") return K_IDENT;
    case (h)
      "+":     return K_ADD_ASGN;
      "-":     return K_SUB_ASGN;
      "*":     return K_MUL_ASGN;
      "/":     return K_DIV_ASGN;
      "=":     return K_EQ;
      "!":     return K_NE;
      "<":     return K_LE;
      ">":     return K_GE;
      "%":     return K_MOD_ASGN;
      default: return K_IDENT;
    endcase
  endfunction

  function automatic kind_e word_class();
    if (word_long) return K_IDENT;
    for (int i = 0; i < 6; i++) begin
      if (word_text == KEYWORD_TEXT[i]) return KEYWORD_KIND[i];
    end
    return K_IDENT;
  endfunction

  function automatic res_t tok(kind_e k, logic [15:0] start, logic [15:0] len,
                               bit closing);
    return '{kind: k, start_offset: start, token_length: len, run_end: closing};
  endfunction

  function automatic void emit(kind_e k, logic [15:0] start, logic [15:0] len,
                               bit closing);
    step_tokens.insert(step_tokens.size(), tok(k, start, len, closing));
  endfunction

  function automatic void clear_lexer();
    scan_mode = SCAN_IDLE;
    held_op   = '0;
    word_text = '0;
    word_long = 1'b0;
    seen_dot  = 1'b0;
    byte_pos  = '0;
    tok_begin = '0;
  endfunction

  // Close whatever token is open, ending it just before offset stop.
  function automatic void flush_token(logic [15:0] stop);
    logic [15:0] span;
    span = (stop >= tok_begin) ? stop - tok_begin : '0;
    case (scan_mode)
      SCAN_WORD:   emit(word_class(), tok_begin, span, 1'b0);
      SCAN_NUMBER: emit(seen_dot ? K_FLOAT : K_INT, tok_begin, span, 1'b0);
      SCAN_HELD:   emit(alone_kind(held_op), tok_begin, span, 1'b0);
      default: ;
    endcase
    scan_mode = SCAN_IDLE;
  endfunction

  function automatic void open_token(logic [7:0] b, logic [15:0] p);
    kind_e k;
    k = single_kind(b);
    if (starts_word(b)) begin
      scan_mode = SCAN_WORD;
      tok_begin = p;
      word_text = {40'd0, b};
      word_long = 1'b0;
    end else if (is_num(b)) begin
      scan_mode = SCAN_NUMBER;
      tok_begin = p;
      seen_dot  = 1'b0;
    end else if (is_space(b)) begin
      scan_mode = SCAN_IDLE;
    end else if (k != K_IDENT) begin
      emit(k, p, 16'd1, 1'b0);
    end else if (alone_kind(b) != K_IDENT) begin
      scan_mode = SCAN_HELD;
      held_op   = b;
      tok_begin = p;
    end else begin
      // anything else, zero and high bytes included, ends the source
      emit(K_BAD_CHAR, p, 16'd1, 1'b1);
      scan_mode = SCAN_DROP;
    end
  endfunction

  function automatic void lex_byte(logic [7:0] b, bit last);
    logic [15:0] p;
    logic [15:0] nxt;
    bit          used;
    kind_e       k;
    step_tokens.delete();
    p    = byte_pos;
    nxt  = (p != POS_MAX) ? p + 16'd1 : p;  // offsets stick at the top
    used = 1'b0;
    // after an error only the final byte matters: it rearms the scanner
    if (scan_mode == SCAN_DROP) begin
      if (last) clear_lexer();
      return;
    end
    live_bytes++;
    case (scan_mode)
      SCAN_WORD: begin
        if (starts_word(b) || is_num(b)) begin
          if (word_text[47:40] != 8'd0) word_long = 1'b1;
          else word_text = {word_text[39:0], b};
          used = 1'b1;
        end else begin
          flush_token(p);
        end
      end
      SCAN_NUMBER: begin
        if (is_num(b)) begin
          used = 1'b1;
        end else if (b == ".") begin
          used = 1'b1;
          if (seen_dot) begin
            emit(K_BAD_NUM, p, 16'd1, 1'b1);
            scan_mode = SCAN_DROP;
          end else begin
            seen_dot = 1'b1;
          end
        end else begin
          flush_token(p);
        end
      end
      SCAN_HELD: begin
        k = pair_kind(held_op, b);
        if (k != K_IDENT) begin
          emit(k, tok_begin, nxt - tok_begin, 1'b0);
          scan_mode = SCAN_IDLE;
          used      = 1'b1;
        end else begin
          flush_token(p);
        end
      end
      default: ;
    endcase
    if (!used) open_token(b, p);
    if (scan_mode == SCAN_DROP) begin
      if (last) clear_lexer();
      else byte_pos = nxt;
    end else if (last) begin
      flush_token(nxt);
      emit(K_END, nxt, 16'd0, 1'b1);
      clear_lexer();
    end else begin
      byte_pos = nxt;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Source builders
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] word_char(bit first);
    int unsigned r;
    r = $urandom_range(0, first ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return "_";
    return 8'("0" + r - 53);
  endfunction

  function automatic logic [7:0] digit_char();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  task automatic append_text(ref logic [7:0] src[$], input logic [63:0] t);
    for (int i = 7; i >= 0; i--) begin
      if (t[8*i +: 8] != 8'd0) src.insert(src.size(), t[8*i +: 8]);
    end
  endtask

  task automatic append_blanks(ref logic [7:0] src[$]);
    repeat ($urandom_range(1, 2)) src.insert(src.size(), BLANK_CHARS[$urandom_range(0, 5)]);
  endtask

  // Mostly well-formed lexemes with random content; a few stray bytes and
  // doubled dots break a source now and then.
  task automatic build_random_source(ref logic [7:0] src[$]);
    int unsigned roll;
    int unsigned n;
    src.delete();
    if ($urandom_range(0, 14) == 0) begin
      repeat ($urandom_range(1, 6)) src.insert(src.size(), 8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(1, 10)) begin
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
        // short words mostly, now and then past the six-byte keyword window
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
        src.insert(src.size(), word_char(1'b1));
        repeat (n - 1) src.insert(src.size(), word_char(1'b0));
      end else if (roll < 32) begin
        append_text(src, 64'(KEYWORD_TEXT[$urandom_range(0, 5)]));
        if ($urandom_range(0, 3) == 0) src.insert(src.size(), word_char(1'b0));
      end else if (roll < 47) begin
        repeat ($urandom_range(1, 5)) src.insert(src.size(), digit_char());
        if ($urandom_range(0, 2) == 0) begin
          src.insert(src.size(), 8'("."));
          repeat ($urandom_range(0, 3)) src.insert(src.size(), digit_char());
          if ($urandom_range(0, 7) == 0) begin
            src.insert(src.size(), 8'("."));
            src.insert(src.size(), digit_char());
          end
        end
      end else if (roll < 82) begin
        append_text(src, 64'(OP_TEXT[$urandom_range(0, 31)]));
      end else if (roll < 97) begin
        append_blanks(src);
      end else begin
        src.insert(src.size(), 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 1) == 1) append_blanks(src);
    end
  endtask

  task automatic send_source(ref logic [7:0] src[$], input bit typed);
    foreach (src[i]) begin
      bytes_out.insert(bytes_out.size(),
                       src_byte_t'{code: src[i], last: (i == src.size() - 1), typed: typed});
    end
    sources_sent++;
  endtask

  task automatic wait_bytes_taken();
    while (bytes_out.size() != 0 || byte_held) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Byte sender: bursts of random length with random gaps. Tokens are
  // predicted at the edge that takes the byte.
  // ---------------------------------------------------------------------------
  initial begin : byte_feed
    src_byte_t   cur;
    int unsigned burst_left;
    int unsigned gap_left;
    cur        = '0;
    burst_left = 0;
    gap_left   = 0;
    item_if.valid      <= 1'b0;
    item_if.char_code  <= '0;
    item_if.final_byte <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (item_if.valid && !item_if.ready) input_stalls++;
      if (byte_held && item_if.valid && item_if.ready) begin
        lex_byte(cur.code, cur.last);
        if (!cur.typed) begin
          foreach (step_tokens[i]) tokens_due.insert(tokens_due.size(), step_tokens[i]);
        end
        byte_held = 1'b0;
      end
      if (!byte_held) begin
        if (gap_left > 0 && !steady) begin
          gap_left--;
        end else if (bytes_out.size() != 0) begin
          cur       = bytes_out.pop_front();
          byte_held = 1'b1;
          gap_left  = 0;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      item_if.valid      <= byte_held;
      item_if.char_code  <= cur.code;
      item_if.final_byte <= cur.last;
    end
  end

  // ---------------------------------------------------------------------------
  // Token sink: ready follows a style that changes after a random stretch;
  // on request it holds off for a long stretch so the token queue fills.
  // ---------------------------------------------------------------------------
  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fails++;
    end
  endtask

  initial begin : token_sink
    sink_style_e style;
    int unsigned style_left;
    int unsigned hold_left;
    int unsigned phase;
    bit          rdy;
    res_t        want;
    style      = SINK_OPEN;
    style_left = 0;
    hold_left  = 0;
    phase      = 0;
    token_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (token_if.valid && token_if.ready) begin
        tokens_seen++;
        if (tokens_due.size() == 0) begin
          $error("token with nothing expected: kind %0d start %0d length %0d end %0d",
                 token_if.kind, token_if.start_offset, token_if.token_length,
                 token_if.run_end);
          fails++;
        end else begin
          want = tokens_due.pop_front();
          check_field("kind", want.kind, token_if.kind);
          check_field("start_offset", want.start_offset, token_if.start_offset);
          check_field("token_length", want.token_length, token_if.token_length);
          check_field("run_end", want.run_end, token_if.run_end);
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (style_left == 0) begin
          style      = sink_style_e'($urandom_range(0, 3));
          style_left = $urandom_range(8, 48);
        end
        style_left--;
        phase++;
        case (style)
          SINK_OPEN:        rdy = 1'b1;
          SINK_COIN:        rdy = $urandom_range(0, 1) == 1;
          SINK_EVERY_THIRD: rdy = (phase % 3) == 0;
          default:          rdy = $urandom_range(0, 7) != 0;
        endcase
      end
      token_if.ready <= rdy;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $error("timeout with %0d tokens still expected", tokens_due.size());
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed sources, pressure burst, all-lexeme pass, then random
  // sources.
  // ---------------------------------------------------------------------------
  function automatic source_row_t row(logic [63:0] text, int len, int n,
                                      res_t t0 = '0, res_t t1 = '0);
    return '{text: text, len: 4'(len), n_fixed: 2'(n), fixed: {t1, t0}};
  endfunction

  initial begin : stimulus
    source_row_t     rows [7];
    logic [7:0]      src [$];
    logic [63:0]     lexemes [$];
    logic [63:0]     swap;
    int unsigned     j;
    int unsigned     base;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Error rows and the first row after reset carry their tokens typed in.
    rows = '{
      row(64'("("),             1, 2, tok(K_LPAREN, 16'd0, 16'd1, 1'b0),
                                      tok(K_END, 16'd1, 16'd0, 1'b1)),
      row(64'h00,               1, 1, tok(K_BAD_CHAR, 16'd0, 16'd1, 1'b1)),
      row(64'({8'hFF, "x"}),    2, 1, tok(K_BAD_CHAR, 16'd0, 16'd1, 1'b1)),
      row(64'("1.2.a "),        6, 1, tok(K_BAD_NUM, 16'd3, 16'd1, 1'b1)),
      row(64'("elseif"),        6, 0),
      row(64'("<="),            2, 0),
      row(64'({8'h09, "7.5>"}), 5, 0)
    };
    foreach (rows[r]) begin
      wait_bytes_taken();
      for (int i = 0; i < rows[r].n_fixed; i++) begin
        tokens_due.insert(tokens_due.size(), rows[r].fixed[i]);
      end
      src.delete();
      for (int i = int'(rows[r].len) - 1; i >= 0; i--) begin
        src.insert(src.size(), rows[r].text[8*i +: 8]);
      end
      send_source(src, rows[r].n_fixed != 0);
    end

    // Back-pressure: the sink stalls while single-byte tokens keep coming.
    wait_bytes_taken();
    steady   = 1'b1;
    hold_req = 1'b1;
    src.delete();
    repeat (20) append_text(src, 64'(OP_TEXT[($urandom_range(0, 1) == 0) ? 0 : 1]));
    send_source(src, 1'b0);
    wait_bytes_taken();
    steady = 1'b0;

    // Every operator and keyword once, in random order.
    for (int i = 0; i < 32; i++) lexemes.insert(lexemes.size(), 64'(OP_TEXT[i]));
    for (int i = 0; i < 6; i++) lexemes.insert(lexemes.size(), 64'(KEYWORD_TEXT[i]));
    for (int i = lexemes.size() - 1; i > 0; i--) begin
      j          = $urandom_range(0, i);
      swap       = lexemes[i];
      lexemes[i] = lexemes[j];
      lexemes[j] = swap;
    end
    src.delete();
    foreach (lexemes[i]) begin
      append_text(src, lexemes[i]);
      append_blanks(src);
    end
    send_source(src, 1'b0);

    base = live_bytes;
    while (live_bytes - base < RANDOM_BYTES) begin
      build_random_source(src);
      send_source(src, 1'b0);
      while (bytes_out.size() != 0) @(posedge clk_i);
    end
    wait_bytes_taken();

    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb: %0d sources, %0d bytes lexed, %0d tokens compared",
             sources_sent, live_bytes, tokens_seen);
    $display("tb: byte input held back %0d cycles under token back-pressure, %0d cycles",
             input_stalls, cycles);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
